[rtl/core/lwbc_pkg.sv]
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types and constants of the LRU write-back block cache tag engine.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam int ENTRY_W     = 5;
  localparam int BLOCK_W     = 32;
  localparam int STAMP_W     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int FLUSH_CNT_W = 5;

  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_BAD,
    DP_DIRECT,
    DP_HIT,
    DP_SCAN_START,
    DP_SCAN,
    DP_INSTALL,
    DP_FLUSH_ONE,
    DP_FLUSH_EMPTY
  } dp_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic op_rw;
    logic op_flush;
    logic bad;
    logic disabled;
    logic hit;
    logic scan_last;
    logic dirty_any;
    logic flush_last;
  } dp_status_t;

  // One result beat.
  typedef struct packed {
    logic               status;
    logic               hit;
    logic [ENTRY_W-1:0] entry_index;
    logic               writeback_needed;
    logic [BLOCK_W-1:0] writeback_block;
    logic               fetch_needed;
    logic               direct_access;
    logic               last;
  } result_t;

endpackage

[rtl/core/lru_writeback_block_cache_tags.sv]
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_tags
// Tag and replacement engine of a fully associative write-back block cache.
// ----------------------------------------------------------------------------
// Hit, bad block, direct access: the result is registered from the lookup state,
//   and a new start is taken only once the engine is idle again. Op 3: no result.
// Miss: the result follows the victim scan, which reads one use stamp per cycle,
//   and then the install. Flush: after the lookup, one beat per cycle from the
//   flush state. Results cannot be stalled.
// Reset (sync rst): tags, stamps, dirty marks, use counter clear; enable is 1.
module lru_writeback_block_cache_tags import lwbc_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: cache_enable
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [BLOCK_W-1:0] block_number,
  // result beats
  output logic               result_valid,
  output logic               status,
  output logic               hit,
  output logic [ENTRY_W-1:0] entry_index,
  output logic               writeback_needed,
  output logic [BLOCK_W-1:0] writeback_block,
  output logic               fetch_needed,
  output logic               direct_access,
  output logic               last
);

  dp_cmd_t    cmd;
  dp_status_t stat;
  result_t    res;

  // Controller: walks lookup -> (scan -> install) or flush, one command/cycle.
  lwbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: all entry state, the match/scan logic and the result register.
  lwbc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .op           (op),
    .block_number (block_number),
    .cmd          (cmd),
    .stat         (stat),
    .res_valid    (result_valid),
    .res          (res)
  );

  assign status           = res.status;
  assign hit              = res.hit;
  assign entry_index      = res.entry_index;
  assign writeback_needed = res.writeback_needed;
  assign writeback_block  = res.writeback_block;
  assign fetch_needed     = res.fetch_needed;
  assign direct_access    = res.direct_access;
  assign last             = res.last;

  // A beat only follows work done in the previous cycle.
  a_beat_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // An accepted request always occupies the engine for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the engine busy");

  // Only flush produces non-final beats, and each of those is a writeback.
  a_mid_beat_wb: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> (writeback_needed && !hit && !fetch_needed))
    else $error("non-final beat is not a flush writeback");

  // A bad-block beat is final and carries nothing else.
  a_bad_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (last && !hit && !writeback_needed && !direct_access))
    else $error("bad-block beat carries other flags");

endmodule

[rtl/core/lwbc_ctrl.sv]
// ----------------------------------------------------------------------------
// lwbc_ctrl
// Request sequencer: lookup, victim scan, install and flush walk.
// ----------------------------------------------------------------------------
module lwbc_ctrl import lwbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_LOOKUP  = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_INSTALL = 5'b01000,
    ST_FLUSH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = DP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd        = DP_LOAD;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        priority if (stat.op_flush) begin
          state_next = ST_FLUSH;
        end else if (!stat.op_rw) begin
          state_next = ST_IDLE;
        end else if (stat.bad) begin
          cmd        = DP_BAD;
          state_next = ST_IDLE;
        end else if (stat.disabled) begin
          cmd        = DP_DIRECT;
          state_next = ST_IDLE;
        end else if (stat.hit) begin
          cmd        = DP_HIT;
          state_next = ST_IDLE;
        end else begin
          cmd        = DP_SCAN_START;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd = DP_SCAN;
        if (stat.scan_last) begin
          state_next = ST_INSTALL;
        end
      end
      ST_INSTALL: begin
        cmd        = DP_INSTALL;
        state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (!stat.dirty_any) begin
          cmd        = DP_FLUSH_EMPTY;
          state_next = ST_IDLE;
        end else begin
          cmd = DP_FLUSH_ONE;
          if (stat.flush_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/core/lwbc_datapath.sv]
// ----------------------------------------------------------------------------
// lwbc_datapath
// Tag, stamp and dirty storage, parallel tag match, serial LRU scan,
// dirty search and result register.
// ----------------------------------------------------------------------------
module lwbc_datapath import lwbc_pkg::*; #(
  parameter int ENTRIES = 32,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [1:0]         op,
  input  logic [BLOCK_W-1:0] block_number,
  input  dp_cmd_t            cmd,
  output dp_status_t         stat,
  output logic               res_valid,
  output result_t            res
);

  logic [BLOCK_W-1:0] tag_block [ENTRIES];
  logic [STAMP_W-1:0] use_stamp [ENTRIES];
  logic [ENTRIES-1:0] dirty_mark;
  logic [STAMP_W-1:0] use_counter;
  logic               cache_enable;

  logic [1:0]             req_op;
  logic [BLOCK_W-1:0]     req_blk;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       victim;
  logic [STAMP_W-1:0]     best;
  logic [FLUSH_CNT_W-1:0] flush_cnt;

  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic               dirty_any;
  logic [IDX_W-1:0]   low_idx;
  logic [ENTRIES-1:0] low_mask;
  logic               flush_last;
  logic [STAMP_W-1:0] cur_stamp;
  logic               res_fire;
  result_t            res_next;

  // lowest-index tag match and lowest-index dirty entry
  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    dirty_any = 1'b0;
    low_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tag_block[i] == req_blk) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (dirty_mark[i]) begin
        dirty_any = 1'b1;
        low_idx   = IDX_W'(i);
      end
    end
  end

  assign low_mask   = {{(ENTRIES-1){1'b0}}, 1'b1} << low_idx;
  assign flush_last = ((dirty_mark & ~low_mask) == '0) ||
                      (flush_cnt == FLUSH_CNT_W'(MAX_RESULTS - 1));
  assign cur_stamp  = use_stamp[scan_idx];

  assign stat.op_rw      = (req_op == OP_READ) || (req_op == OP_WRITE);
  assign stat.op_flush   = (req_op == OP_FLUSH);
  assign stat.bad        = (req_blk == '0);
  assign stat.disabled   = !cache_enable;
  assign stat.hit        = hit_any;
  assign stat.scan_last  = (scan_idx == IDX_W'(ENTRIES - 1));
  assign stat.dirty_any  = dirty_any;
  assign stat.flush_last = flush_last;

  always_comb begin
    res_fire = 1'b0;
    res_next = '0;
    unique case (cmd)
      DP_BAD: begin
        res_fire        = 1'b1;
        res_next.status = 1'b1;
        res_next.last   = 1'b1;
      end
      DP_DIRECT: begin
        res_fire               = 1'b1;
        res_next.direct_access = 1'b1;
        res_next.last          = 1'b1;
      end
      DP_HIT: begin
        res_fire             = 1'b1;
        res_next.hit         = 1'b1;
        res_next.entry_index = ENTRY_W'(hit_idx);
        res_next.last        = 1'b1;
      end
      DP_INSTALL: begin
        res_fire                  = 1'b1;
        res_next.entry_index      = ENTRY_W'(victim);
        res_next.writeback_needed = dirty_mark[victim];
        res_next.writeback_block  = dirty_mark[victim] ? tag_block[victim] : '0;
        res_next.fetch_needed     = (req_op == OP_READ);
        res_next.last             = 1'b1;
      end
      DP_FLUSH_ONE: begin
        res_fire                  = 1'b1;
        res_next.entry_index      = ENTRY_W'(low_idx);
        res_next.writeback_needed = 1'b1;
        res_next.writeback_block  = tag_block[low_idx];
        res_next.last             = flush_last;
      end
      DP_FLUSH_EMPTY: begin
        res_fire      = 1'b1;
        res_next.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      cache_enable <= 1'b1;
      use_counter  <= '0;
      dirty_mark   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_block[i] <= '0;
        use_stamp[i] <= '0;
      end
    end else begin
      res_valid <= res_fire;
      if (cfg_wr_en) begin
        cache_enable <= cfg_wr_data;
      end
      unique case (cmd)
        DP_HIT: begin
          use_stamp[hit_idx] <= use_counter;
          use_counter        <= use_counter + 1'b1;
          if (req_op == OP_WRITE) begin
            dirty_mark[hit_idx] <= 1'b1;
          end
        end
        DP_INSTALL: begin
          tag_block[victim]  <= req_blk;
          use_stamp[victim]  <= use_counter;
          dirty_mark[victim] <= (req_op == OP_WRITE);
          use_counter        <= use_counter + 1'b1;
        end
        DP_FLUSH_ONE: begin
          dirty_mark[low_idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register, request capture, scan and flush counters (no reset needed)
  always_ff @(posedge clk) begin
    if (res_fire) begin
      res <= res_next;
    end
    unique case (cmd)
      DP_LOAD: begin
        req_op    <= op;
        req_blk   <= block_number;
        flush_cnt <= '0;
      end
      DP_SCAN_START: begin
        scan_idx <= '0;
        best     <= STAMP_MAX;
        victim   <= '0;
      end
      DP_SCAN: begin
        if (cur_stamp < best) begin
          best   <= cur_stamp;
          victim <= scan_idx;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      DP_FLUSH_ONE: begin
        flush_cnt <= flush_cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/lru_writeback_block_cache_tags_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_tags_tb
// Self-checking bench for the LRU write-back cache tag engine. A shadow copy
// of tags, stamps, dirty marks and the use counter predicts every result beat.
// Directed cases come first, then random traffic over a small block pool.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_tags_tb;
  import lwbc_pkg::*;

  localparam int NUM_ENTRIES   = 32;
  localparam int HOT_COUNT     = 48;   // a bit more than the entries: hits and evictions both
  localparam int SETTLE_CYCLES = 4;    // op 3 gives no beat but still makes the block busy
  localparam int TAIL_CYCLES   = NUM_ENTRIES + 8;  // longest silent stretch (victim scan)
  localparam int PRINT_CAP     = 100;

  // op 3 is not defined: the block drops it without a beat
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // ---- clock, reset, block inputs (all known from time 0) ----
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         op = OP_READ;
  logic [BLOCK_W-1:0] block_number = '0;

  logic               busy;
  logic               result_valid;
  logic               status;
  logic               hit;
  logic [ENTRY_W-1:0] entry_index;
  logic               writeback_needed;
  logic [BLOCK_W-1:0] writeback_block;
  logic               fetch_needed;
  logic               direct_access;
  logic               last;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_writeback_block_cache_tags #(
    .ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .op               (op),
    .block_number     (block_number),
    .result_valid     (result_valid),
    .status           (status),
    .hit              (hit),
    .entry_index      (entry_index),
    .writeback_needed (writeback_needed),
    .writeback_block  (writeback_block),
    .fetch_needed     (fetch_needed),
    .direct_access    (direct_access),
    .last             (last)
  );

  // ---- shadow of the tag engine ----
  logic [BLOCK_W-1:0] sh_tag   [NUM_ENTRIES];
  logic [STAMP_W-1:0] sh_stamp [NUM_ENTRIES];
  logic               sh_dirty [NUM_ENTRIES];
  logic [STAMP_W-1:0] sh_clock;
  logic               sh_enable;

  result_t            owed_beats[$];   // predicted beats, oldest first
  logic [BLOCK_W-1:0] hot_blocks[HOT_COUNT];
  int                 err_count = 0;
  bit                 idle_on = 1'b1;

  task automatic log_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    if (got_v !== want_v)
      log_mismatch($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
  endtask

  // Works out the beats one accepted request causes and updates the shadow.
  function automatic void resolve_request(input logic [1:0] req_op,
                                          input logic [BLOCK_W-1:0] blk);
    result_t            beat;
    int                 i;
    int                 found;
    int                 victim;
    int                 total;
    int                 n;
    logic [STAMP_W-1:0] best;

    beat = '0;
    if (req_op == OP_UNDEF)
      return;

    // flush ignores the enable; one beat per dirty entry in index order
    if (req_op == OP_FLUSH) begin
      total = 0;
      for (i = 0; i < NUM_ENTRIES; i++)
        if (sh_dirty[i]) total++;
      if (total > MAX_RESULTS) total = MAX_RESULTS;
      if (total == 0) begin
        beat.last = 1'b1;
        owed_beats.push_back(beat);
        return;
      end
      n = 0;
      for (i = 0; i < NUM_ENTRIES; i++) begin
        if (sh_dirty[i] && n < total) begin
          beat                  = '0;
          beat.entry_index      = i[ENTRY_W-1:0];
          beat.writeback_needed = 1'b1;
          beat.writeback_block  = sh_tag[i];
          n++;
          beat.last             = (n == total);
          sh_dirty[i]           = 1'b0;
          owed_beats.push_back(beat);
        end
      end
      return;
    end

    beat.last = 1'b1;
    // bad block wins over the enable check
    if (blk == '0) begin
      beat.status = 1'b1;
      owed_beats.push_back(beat);
      return;
    end
    if (!sh_enable) begin
      beat.direct_access = 1'b1;
      owed_beats.push_back(beat);
      return;
    end

    found = -1;
    for (i = NUM_ENTRIES - 1; i >= 0; i--)
      if (sh_tag[i] == blk) found = i;
    if (found >= 0) begin
      sh_stamp[found] = sh_clock;
      sh_clock        = sh_clock + 1'b1;
      if (req_op == OP_WRITE) sh_dirty[found] = 1'b1;
      beat.hit         = 1'b1;
      beat.entry_index = found[ENTRY_W-1:0];
      owed_beats.push_back(beat);
      return;
    end

    // miss: oldest stamp, lowest index on ties, entry 0 if all at max
    victim = 0;
    best   = STAMP_MAX;
    for (i = 0; i < NUM_ENTRIES; i++)
      if (sh_stamp[i] < best) begin
        best   = sh_stamp[i];
        victim = i;
      end
    beat.entry_index = victim[ENTRY_W-1:0];
    if (sh_dirty[victim]) begin
      beat.writeback_needed = 1'b1;
      beat.writeback_block  = sh_tag[victim];
    end
    beat.fetch_needed = (req_op == OP_READ);
    sh_tag[victim]    = blk;
    sh_stamp[victim]  = sh_clock;
    sh_clock          = sh_clock + 1'b1;
    sh_dirty[victim]  = (req_op == OP_WRITE);
    owed_beats.push_back(beat);
  endfunction

  // Result checker: every strobed beat against the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid) begin
      got.status           = status;
      got.hit              = hit;
      got.entry_index      = entry_index;
      got.writeback_needed = writeback_needed;
      got.writeback_block  = writeback_block;
      got.fetch_needed     = fetch_needed;
      got.direct_access    = direct_access;
      got.last             = last;
      if (owed_beats.size() == 0) begin
        log_mismatch($sformatf("unexpected beat, entry %0d block %0h",
                               got.entry_index, got.writeback_block));
      end else begin
        want = owed_beats.pop_front();
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("hit", 32'(got.hit), 32'(want.hit));
        compare_field("entry_index", 32'(got.entry_index), 32'(want.entry_index));
        compare_field("writeback_needed", 32'(got.writeback_needed),
                      32'(want.writeback_needed));
        compare_field("writeback_block", got.writeback_block, want.writeback_block);
        compare_field("fetch_needed", 32'(got.fetch_needed), 32'(want.fetch_needed));
        compare_field("direct_access", 32'(got.direct_access),
                      32'(want.direct_access));
        compare_field("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // One request beat. Start stays high after acceptance until the caller's
  // next negedge action (another request, a gap or a settle).
  task automatic send_beat(input logic [1:0] req_op, input logic [BLOCK_W-1:0] blk);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 16)
      gap = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    op           <= req_op;
    block_number <= blk;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    resolve_request(req_op, blk);
  endtask

  // Drop start, let every owed beat come out, then a few quiet cycles.
  task automatic settle_idle;
    @(negedge clk);
    start <= 1'b0;
    while (owed_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cache_enable(input bit value);
    settle_idle;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sh_enable    = value;
  endtask

  // ---- tests ----

  // Nothing dirty yet: flush gives one empty beat. Op 3 is dropped.
  task automatic test_empty_flush;
    send_beat(OP_FLUSH, 32'h0000_0000);
    send_beat(OP_UNDEF, 32'h1234_5678);
    send_beat(OP_FLUSH, 32'hFFFF_FFFF);
  endtask

  task automatic test_bad_block;
    send_beat(OP_READ, '0);
    send_beat(OP_WRITE, '0);
  endtask

  task automatic test_fill_and_hit;
    send_beat(OP_WRITE, 32'hFFFF_FFFF);  // write miss, entry 0 dirty, stamp 0
    send_beat(OP_READ, 32'h0000_0001);   // all stamps tie at 0: entry 0 again, dirty victim
    send_beat(OP_WRITE, 32'h8000_0000);  // next oldest is entry 1
    send_beat(OP_READ, 32'h0000_0001);   // read hit
    send_beat(OP_WRITE, 32'h0000_0001);  // write hit marks dirty
    send_beat(OP_READ, 32'h8000_0000);   // hit on a dirty entry
    send_beat(OP_READ, 32'h5555_AAAA);
    send_beat(OP_WRITE, 32'hAAAA_5555);
  endtask

  task automatic test_flush_dirty;
    send_beat(OP_FLUSH, 32'h0BAD_F00D);  // several dirty entries, last on the final one
    send_beat(OP_FLUSH, 32'h0000_0000);  // all clean now
  endtask

  task automatic test_cache_disabled;
    send_beat(OP_WRITE, 32'h5555_AAAA);  // make one entry dirty first
    write_cache_enable(1'b0);
    send_beat(OP_READ, 32'h5555_AAAA);   // held, but still goes direct
    send_beat(OP_WRITE, 32'h0000_0007);
    send_beat(OP_READ, '0);              // bad block beats the disable
    send_beat(OP_WRITE, '0);
    send_beat(OP_FLUSH, 32'h0000_0000);  // flush runs regardless
    send_beat(OP_UNDEF, 32'hFFFF_FFFF);
    write_cache_enable(1'b1);
    send_beat(OP_READ, 32'h5555_AAAA);   // hit again, tags untouched while off
  endtask

  // Mostly reads and writes over a hot pool, some flushes, bad blocks and
  // wide random blocks. Op 3 items do not count.
  task automatic test_random_traffic(input int n_items, input bit with_idle);
    int                 sent;
    int                 roll;
    logic [1:0]         req_op;
    logic [BLOCK_W-1:0] blk;
    idle_on = with_idle;
    sent    = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 44)      req_op = OP_READ;
      else if (roll < 88) req_op = OP_WRITE;
      else if (roll < 95) req_op = OP_FLUSH;
      else                req_op = OP_UNDEF;
      roll = $urandom_range(99);
      if (roll < 3)       blk = '0;
      else if (roll < 88) blk = hot_blocks[$urandom_range(HOT_COUNT - 1)];
      else                blk = $urandom;
      send_beat(req_op, blk);
      if (req_op != OP_UNDEF) sent++;
    end
  endtask

  // ---- sequence ----
  initial begin
    int i;
    logic [BLOCK_W-1:0] v;

    for (i = 0; i < NUM_ENTRIES; i++) begin
      sh_tag[i]   = '0;
      sh_stamp[i] = '0;
      sh_dirty[i] = 1'b0;
    end
    sh_clock  = '0;
    sh_enable = 1'b1;

    hot_blocks[0] = 32'h0000_0001;
    hot_blocks[1] = 32'hFFFF_FFFF;
    for (i = 2; i < HOT_COUNT; i++) begin
      v = $urandom;
      if (v == '0) v = 32'h0000_0002;
      hot_blocks[i] = v;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_flush;
    test_bad_block;
    test_fill_and_hit;
    test_flush_dirty;
    test_cache_disabled;

    test_random_traffic(130, 1'b1);
    test_random_traffic(90, 1'b0);      // back-to-back, no gaps at all
    write_cache_enable(1'b0);
    test_random_traffic(40, 1'b1);
    write_cache_enable(1'b1);
    test_random_traffic(130, 1'b1);

    settle_idle;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every miss scanning, every gap long).
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
